[hw/rtl/assert_macros.svh]
// Assertion macros shared by the voxel merge RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TSVM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voxel merge assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TSVM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voxel merge assertion failed");

`endif

[hw/rtl/tsvm_pkg.sv]
// Package for the voxel merge core: field widths, item structs and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tsvm_pkg;

  localparam int DIST_BITS   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int LABEL_BITS  = 16;
  localparam int COUNT_BITS  = 16;
  localparam int RGB_BITS    = 24;
  localparam int RGBA_BITS   = 32;
  localparam int ALPHA_BITS  = RGBA_BITS - RGB_BITS;

  localparam int NUM_BITS    = DIST_BITS + WEIGHT_BITS;
  localparam int SUM_BITS    = WEIGHT_BITS + 1;

  // Count vote: x = 2 * (t + b_count), divided by three through a reciprocal.
  localparam int CX_BITS     = COUNT_BITS + 2;
  localparam int DIV3_SHIFT  = CX_BITS + 2;
  localparam int DIV3_PBITS  = CX_BITS + DIV3_SHIFT;
  localparam logic [DIV3_SHIFT-1:0] DIV3_MULT =
    DIV3_SHIFT'((64'd1 << DIV3_SHIFT) / 64'd3);

  localparam logic [ALPHA_BITS-1:0] ALPHA_OPAQUE = '1;

  typedef struct packed {
    logic signed [DIST_BITS-1:0] a_distance;
    logic [WEIGHT_BITS-1:0]      a_weight;
    logic [LABEL_BITS-1:0]       a_label;
    logic [COUNT_BITS-1:0]       a_count;
    logic [RGB_BITS-1:0]         a_rgb;
    logic signed [DIST_BITS-1:0] b_distance;
    logic [WEIGHT_BITS-1:0]      b_weight;
    logic [LABEL_BITS-1:0]       b_label;
    logic [COUNT_BITS-1:0]       b_count;
    logic [RGBA_BITS-1:0]        b_rgba;
  } in_item_t;

  typedef struct packed {
    logic                        merged;
    logic signed [DIST_BITS-1:0] out_distance;
    logic [WEIGHT_BITS-1:0]      out_weight;
    logic [LABEL_BITS-1:0]       out_label;
    logic [COUNT_BITS-1:0]       out_count;
    logic [RGBA_BITS-1:0]        out_rgba;
  } out_item_t;

  typedef struct packed {
    logic                   merged;
    logic                   neg;
    logic [DIST_BITS-1:0]   b_distance;
    logic [WEIGHT_BITS-1:0] weight;
    logic [LABEL_BITS-1:0]  label;
    logic [COUNT_BITS-1:0]  count;
    logic [RGBA_BITS-1:0]   rgba;
  } side_t;

  typedef struct packed {
    logic [NUM_BITS-1:0] num;
    logic [SUM_BITS-1:0] den;
    side_t               side;
  } div_req_t;

endpackage

`default_nettype wire

[hw/rtl/tsvm_front.sv]
// Front end of the voxel merge: three stages of products, sign combine and vote logic.
// Depends on tsvm_pkg; feeds the pipelined divider.
`default_nettype none

module tsvm_front import tsvm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [RGB_BITS-1:0] background_rgb,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                dv_valid,
  input  logic                dv_ready,
  output div_req_t            dv_req
);

  typedef struct packed {
    logic [NUM_BITS-1:0]    pa;
    logic [NUM_BITS-1:0]    pb;
    logic                   neg_a;
    logic                   neg_b;
    logic [SUM_BITS-1:0]    sum;
    logic [COUNT_BITS-1:0]  t;
    logic [LABEL_BITS-1:0]  al;
    logic [RGB_BITS-1:0]    argb;
    logic [RGBA_BITS-1:0]   rgba_def;
    logic [DIST_BITS-1:0]   bd;
    logic [WEIGHT_BITS-1:0] bw;
    logic [LABEL_BITS-1:0]  bl;
    logic [COUNT_BITS-1:0]  bc;
    logic [RGBA_BITS-1:0]   brgba;
  } st1_t;

  typedef struct packed {
    logic [NUM_BITS-1:0]    num;
    logic                   neg;
    logic [SUM_BITS-1:0]    sum;
    logic [CX_BITS-1:0]     x;
    logic [DIV3_PBITS-1:0]  prod;
    logic                   equal;
    logic                   takes_over;
    logic [COUNT_BITS-1:0]  cnt_ab;
    logic [COUNT_BITS-1:0]  cnt_ba;
    logic [LABEL_BITS-1:0]  al;
    logic [RGB_BITS-1:0]    argb;
    logic [RGBA_BITS-1:0]   rgba_def;
    logic [DIST_BITS-1:0]   bd;
    logic [WEIGHT_BITS-1:0] bw;
    logic [LABEL_BITS-1:0]  bl;
    logic [COUNT_BITS-1:0]  bc;
    logic [RGBA_BITS-1:0]   brgba;
  } st2_t;

  logic     v1, v2, v3;
  logic     rdy1, rdy2, rdy3;
  st1_t     s1, s1_next;
  st2_t     s2, s2_next;
  div_req_t s3_next;

  logic [DIST_BITS-1:0]  ua, ub, mag_a, mag_b;
  logic [COUNT_BITS:0]   tb;
  logic [CX_BITS-1:0]    q0, c;
  logic [CX_BITS+1:0]    q3, r;
  logic [COUNT_BITS-1:0] csat;

  assign rdy3     = !v3 || dv_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign dv_valid = v3;

  always_comb begin
    ua    = in_item.a_distance;
    ub    = in_item.b_distance;
    mag_a = ua[DIST_BITS-1] ? (~ua + 1'b1) : ua;
    mag_b = ub[DIST_BITS-1] ? (~ub + 1'b1) : ub;
    s1_next.pa    = NUM_BITS'(mag_a) * NUM_BITS'(in_item.a_weight);
    s1_next.pb    = NUM_BITS'(mag_b) * NUM_BITS'(in_item.b_weight);
    s1_next.neg_a = ua[DIST_BITS-1];
    s1_next.neg_b = ub[DIST_BITS-1];
    s1_next.sum   = {1'b0, in_item.a_weight} + {1'b0, in_item.b_weight};
    s1_next.t     = (in_item.a_label == '0 && in_item.a_rgb != '0) ?
                    (in_item.a_count >> 1) : in_item.a_count;
    s1_next.al    = in_item.a_label;
    s1_next.argb  = in_item.a_rgb;
    s1_next.rgba_def = (in_item.b_rgba[RGBA_BITS-1:ALPHA_BITS] == '0) ?
                       {background_rgb, ALPHA_OPAQUE} : in_item.b_rgba;
    s1_next.bd    = in_item.b_distance;
    s1_next.bw    = in_item.b_weight;
    s1_next.bl    = in_item.b_label;
    s1_next.bc    = in_item.b_count;
    s1_next.brgba = in_item.b_rgba;
  end

  always_comb begin
    if (s1.neg_a == s1.neg_b) begin
      s2_next.num = s1.pa + s1.pb;
      s2_next.neg = s1.neg_a;
    end else if (s1.pa >= s1.pb) begin
      s2_next.num = s1.pa - s1.pb;
      s2_next.neg = s1.neg_a;
    end else begin
      s2_next.num = s1.pb - s1.pa;
      s2_next.neg = s1.neg_b;
    end
    tb = {1'b0, s1.t} + {1'b0, s1.bc};
    s2_next.sum      = s1.sum;
    s2_next.x        = {tb, 1'b0};
    s2_next.prod     = DIV3_PBITS'({tb, 1'b0}) * DIV3_PBITS'(DIV3_MULT);
    s2_next.equal    = (s1.al == s1.bl);
    s2_next.takes_over = (s1.t >= s1.bc && s1.t > COUNT_BITS'(1)) ||
                         (s1.t == COUNT_BITS'(1) && s1.bc == '0);
    s2_next.cnt_ab   = s1.t - s1.bc;
    s2_next.cnt_ba   = (s1.bc > s1.t) ? (s1.bc - s1.t) : '0;
    s2_next.al       = s1.al;
    s2_next.argb     = s1.argb;
    s2_next.rgba_def = s1.rgba_def;
    s2_next.bd       = s1.bd;
    s2_next.bw       = s1.bw;
    s2_next.bl       = s1.bl;
    s2_next.bc       = s1.bc;
    s2_next.brgba    = s1.brgba;
  end

  always_comb begin
    q0 = s2.prod[DIV3_PBITS-1:DIV3_SHIFT];
    q3 = {2'b00, q0} + {1'b0, q0, 1'b0};
    r  = {2'b00, s2.x} - q3;
    c  = (r >= (CX_BITS+2)'(3)) ? (q0 + 1'b1) : q0;
    csat = (c[CX_BITS-1:COUNT_BITS] != '0) ? '1 : c[COUNT_BITS-1:0];

    s3_next.num = s2.num;
    s3_next.den = s2.sum;
    s3_next.side.neg        = s2.neg;
    s3_next.side.b_distance = s2.bd;
    if (s2.sum == '0) begin
      s3_next.side.merged = 1'b0;
      s3_next.side.weight = s2.bw;
      s3_next.side.label  = s2.bl;
      s3_next.side.count  = s2.bc;
      s3_next.side.rgba   = s2.brgba;
    end else begin
      s3_next.side.merged = 1'b1;
      s3_next.side.weight = s2.sum[WEIGHT_BITS] ? '1 : s2.sum[WEIGHT_BITS-1:0];
      if (s2.equal) begin
        s3_next.side.label = s2.bl;
        s3_next.side.count = csat;
        s3_next.side.rgba  = s2.rgba_def;
      end else if (s2.takes_over) begin
        s3_next.side.label = s2.al;
        s3_next.side.count = s2.cnt_ab;
        s3_next.side.rgba  = {s2.argb, ALPHA_OPAQUE};
      end else begin
        s3_next.side.label = s2.bl;
        s3_next.side.count = s2.cnt_ba;
        s3_next.side.rgba  = s2.rgba_def;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1 <= s1_next;
    end
    if (rdy2 && v1) begin
      s2 <= s2_next;
    end
    if (rdy3 && v2) begin
      dv_req <= s3_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tsvm_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, DIST_BITS stages.
// Depends on tsvm_pkg and assert_macros.svh; carries the side fields along.
`default_nettype none
`include "assert_macros.svh"

module tsvm_divider import tsvm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  div_req_t             req,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [DIST_BITS-1:0] res_quot,
  output side_t                res_side
);

  logic [DIST_BITS-1:0] v, rdy, src_v;
  logic [NUM_BITS-1:0]  rem       [DIST_BITS];
  logic [NUM_BITS-1:0]  rem_next  [DIST_BITS];
  logic [NUM_BITS-1:0]  src_rem   [DIST_BITS];
  logic [NUM_BITS-1:0]  trial     [DIST_BITS];
  logic [SUM_BITS-1:0]  den       [DIST_BITS];
  logic [SUM_BITS-1:0]  src_den   [DIST_BITS];
  logic [DIST_BITS-1:0] quot      [DIST_BITS];
  logic [DIST_BITS-1:0] quot_next [DIST_BITS];
  side_t                side      [DIST_BITS];
  side_t                src_side  [DIST_BITS];

  always_comb begin
    rdy[DIST_BITS-1] = !v[DIST_BITS-1] || res_ready;
    for (int i = DIST_BITS - 2; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < DIST_BITS; i++) begin
      if (i == 0) begin
        src_v[i]    = req_valid;
        src_rem[i]  = req.num;
        src_den[i]  = req.den;
        src_side[i] = req.side;
        quot_next[i] = '0;
      end else begin
        src_v[i]    = v[i-1];
        src_rem[i]  = rem[i-1];
        src_den[i]  = den[i-1];
        src_side[i] = side[i-1];
        quot_next[i] = quot[i-1];
      end
      trial[i] = NUM_BITS'(src_den[i]) << (DIST_BITS - 1 - i);
      if (src_rem[i] >= trial[i]) begin
        rem_next[i] = src_rem[i] - trial[i];
        quot_next[i][DIST_BITS-1-i] = 1'b1;
      end else begin
        rem_next[i] = src_rem[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < DIST_BITS; i++) begin
        if (rdy[i]) begin
          v[i] <= src_v[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIST_BITS; i++) begin
      if (rdy[i] && src_v[i]) begin
        rem[i]  <= rem_next[i];
        den[i]  <= src_den[i];
        quot[i] <= quot_next[i];
        side[i] <= src_side[i];
      end
    end
  end

  assign req_ready = rdy[0];
  assign res_valid = v[DIST_BITS-1];
  assign res_quot  = quot[DIST_BITS-1];
  assign res_side  = side[DIST_BITS-1];

  `TSVM_ASSERT_IMPLY(a_rem_below_den, v[DIST_BITS-1] && den[DIST_BITS-1] != '0, rem[DIST_BITS-1] < NUM_BITS'(den[DIST_BITS-1]))
  `TSVM_ASSERT_IMPLY(a_stall_only_when_full, !req_ready, v[0])

endmodule

`default_nettype wire

[hw/rtl/tsdf_semantic_voxel_merge_core.sv]
// Top level of the semantic voxel merge: configuration register, front end,
// divider and output register. Depends on tsvm_pkg, tsvm_front, tsvm_divider.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_item   (in_item_t)
//   out      output     out_valid/out_ready  out_item  (out_item_t)
//   cfg      input      cfg_valid/cfg_ready  cfg_data  (background color)
//
// One item is taken per cycle while no stall on the output holds the stages.
// The divider resolves one quotient bit per stage.
// Reset clears every valid bit and sets the background color to zero.
// Each stage holds while the next is full and fills whenever it is empty,
// so a stall on the output loses and repeats no item.
`default_nettype none
`include "assert_macros.svh"

module tsdf_semantic_voxel_merge_core import tsvm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RGB_BITS-1:0] cfg_data
);

  logic [RGB_BITS-1:0]  background_rgb;
  logic                 dv_valid, dv_ready;
  div_req_t             dv_req;
  logic                 res_valid, res_ready;
  logic [DIST_BITS-1:0] res_quot;
  side_t                res_side;
  out_item_t            out_item_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      background_rgb <= '0;
    end else if (cfg_valid && cfg_ready) begin
      background_rgb <= cfg_data;
    end
  end

  tsvm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .background_rgb (background_rgb),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .dv_valid       (dv_valid),
    .dv_ready       (dv_ready),
    .dv_req         (dv_req)
  );

  tsvm_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .req_valid (dv_valid),
    .req_ready (dv_ready),
    .req       (dv_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_quot  (res_quot),
    .res_side  (res_side)
  );

  assign res_ready = !out_valid || out_ready;

  always_comb begin
    out_item_next.merged = res_side.merged;
    if (res_side.merged) begin
      out_item_next.out_distance = res_side.neg ? (~res_quot + 1'b1) : res_quot;
    end else begin
      out_item_next.out_distance = res_side.b_distance;
    end
    out_item_next.out_weight = res_side.weight;
    out_item_next.out_label  = res_side.label;
    out_item_next.out_count  = res_side.count;
    out_item_next.out_rgba   = res_side.rgba;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_item <= out_item_next;
    end
  end

  `TSVM_ASSERT_IMPLY(a_merged_iff_weight, out_valid, out_item.merged == (out_item.out_weight != '0))
  `TSVM_ASSERT_NEXT(a_result_reaches_output, res_valid && res_ready, out_valid)

endmodule

`default_nettype wire
